@@ rtl/rsba_pkg.sv @@
// ----------------------------------------------------------------------------
// rsba_pkg: shared types and constants of the slot bitmap allocator
// Opcodes, result status codes, field widths, controller/datapath bundles, first-zero search.
// ----------------------------------------------------------------------------
package rsba_pkg;

  localparam int unsigned HandleW  = 10;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgW     = 11;
  localparam int unsigned CountW   = 16;
  localparam int unsigned WordBits = 32;

  localparam logic [CfgW-1:0]   UsableReset = 11'd1024;
  localparam logic [CountW-1:0] CountMax    = 16'hFFFF;

  localparam logic OpAdd    = 1'b0;
  localparam logic OpRemove = 1'b1;

  localparam logic [StatusW-1:0] StNew          = 3'd0;
  localparam logic [StatusW-1:0] StShared       = 3'd1;
  localparam logic [StatusW-1:0] StFull         = 3'd2;
  localparam logic [StatusW-1:0] StSaturated    = 3'd3;
  localparam logic [StatusW-1:0] StDropped      = 3'd4;
  localparam logic [StatusW-1:0] StFreed        = 3'd5;
  localparam logic [StatusW-1:0] StUnregistered = 3'd6;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic lookup;
    logic scan;
    logic free_wr;
    logic load_out;
  } rsba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic need_scan;
    logic need_free;
    logic scan_done;
  } rsba_stat_t;

  // Position of the lowest zero bit, binary search in five halving steps
  function automatic logic [4:0] first_zero(input logic [WordBits-1:0] w);
    logic [WordBits-1:0] x;
    logic [4:0]          p;
    x = ~w;
    p = '0;
    if (x[15:0] == 16'd0) begin
      p[4] = 1'b1;
      x    = x >> 16;
    end
    if (x[7:0] == 8'd0) begin
      p[3] = 1'b1;
      x    = x >> 8;
    end
    if (x[3:0] == 4'd0) begin
      p[2] = 1'b1;
      x    = x >> 4;
    end
    if (x[1:0] == 2'd0) begin
      p[1] = 1'b1;
      x    = x >> 2;
    end
    if (x[0] == 1'b0) begin
      p[0] = 1'b1;
    end
    return p;
  endfunction

endpackage

@@ rtl/refcounted_slot_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// refcounted_slot_bitmap_allocator: handle to slot mapping with ref counts
// First-fit slot bitmap, per-handle reference count, full/saturation status.
//
//   channel  signals                          direction  payload
//   in       in_valid_i / in_ready_o          sink       opcode_i, handle_i
//   out      out_valid_o / out_ready_i        source     slot_o, status_o
//   cfg      cfg_valid_i / cfg_ready_o        sink       usable_slots_i
//
// Add for a held handle, remove: accept, table lookup, result handoff; a
// remove that frees the slot adds a bitmap write. New allocation: lookup,
// then a scan of 1 to ceil(SLOTS/32) words, one bitmap word a cycle through
// the bitmap RAM read port. After reset a clearing pass over max(HANDLES,
// ceil(SLOTS/32)) addresses (1024 by default) zeroes the tables; in_ready_o
// stays low, cfg writes are taken. A stalled output holds one result while the next item is accepted.
// ----------------------------------------------------------------------------
module refcounted_slot_bitmap_allocator #(
  parameter int unsigned HANDLES = 1024,
  parameter int unsigned SLOTS   = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [rsba_pkg::HandleW-1:0]     handle_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rsba_pkg::SlotW-1:0]       slot_o,
  output logic [rsba_pkg::StatusW-1:0]     status_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rsba_pkg::CfgW-1:0]        usable_slots_i
);

  rsba_pkg::rsba_cmd_t            cmd;
  rsba_pkg::rsba_stat_t           stat;
  logic [rsba_pkg::CfgW-1:0]      usable_q;
  logic                           out_valid_q;
  logic [rsba_pkg::SlotW-1:0]     out_slot_q;
  logic [rsba_pkg::StatusW-1:0]   out_status_q;
  logic [rsba_pkg::SlotW-1:0]     res_slot;
  logic [rsba_pkg::StatusW-1:0]   res_status;
  logic                           out_free;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q <= rsba_pkg::UsableReset;
    end else if (cfg_valid_i) begin
      usable_q <= usable_slots_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) begin
      out_slot_q   <= res_slot;
      out_status_q <= res_status;
    end
  end

  rsba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rsba_dp #(
    .HANDLES (HANDLES),
    .SLOTS   (SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (opcode_i),
    .handle_i       (handle_i),
    .usable_slots_i (usable_q),
    .res_slot_o     (res_slot),
    .res_status_o   (res_status)
  );

  assign out_valid_o = out_valid_q;
  assign slot_o      = out_slot_q;
  assign status_o    = out_status_q;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= rsba_pkg::StUnregistered)
    else $error("result status outside the defined codes");

  a_no_slot_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == rsba_pkg::StFull ||
                     status_o == rsba_pkg::StUnregistered)) |-> slot_o == '0)
    else $error("full or unregistered result carries a slot");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction accepted while one is in progress");

endmodule

@@ rtl/rsba_ram.sv @@
// ----------------------------------------------------------------------------
// rsba_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held without read.
// ----------------------------------------------------------------------------
module rsba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rsba_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsba_ctrl: sequencer of the slot bitmap allocator
// Clearing pass after reset, then lookup, word scan or free, result handoff.
// ----------------------------------------------------------------------------
module rsba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_free_i,
  input  rsba_pkg::rsba_stat_t stat_i,
  output rsba_pkg::rsba_cmd_t  cmd_o
);

  localparam logic [2:0] SClear  = 3'd0;
  localparam logic [2:0] SIdle   = 3'd1;
  localparam logic [2:0] SLookup = 3'd2;
  localparam logic [2:0] SScan   = 3'd3;
  localparam logic [2:0] SFree   = 3'd4;
  localparam logic [2:0] SDone   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SClear: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = SLookup;
        end
      end
      SLookup: begin
        cmd_o.lookup = 1'b1;
        priority if (stat_i.need_scan) begin
          state_d = SScan;
        end else if (stat_i.need_free) begin
          state_d = SFree;
        end else begin
          state_d = SDone;
        end
      end
      SScan: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = SDone;
        end
      end
      SFree: begin
        cmd_o.free_wr = 1'b1;
        state_d       = SDone;
      end
      SDone: begin
        // hold the result until the output register frees up
        if (out_free_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == SIdle);

endmodule

@@ rtl/rsba_dp.sv @@
// ----------------------------------------------------------------------------
// rsba_dp: datapath of the slot bitmap allocator
// Handle table (count and slot per handle), slot bitmap words, scan logic.
// ----------------------------------------------------------------------------
module rsba_dp #(
  parameter int unsigned HANDLES = 1024,
  parameter int unsigned SLOTS   = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rsba_pkg::rsba_cmd_t                cmd_i,
  output rsba_pkg::rsba_stat_t               stat_o,
  input  logic                               opcode_i,
  input  logic [rsba_pkg::HandleW-1:0]       handle_i,
  input  logic [rsba_pkg::CfgW-1:0]          usable_slots_i,
  output logic [rsba_pkg::SlotW-1:0]         res_slot_o,
  output logic [rsba_pkg::StatusW-1:0]       res_status_o
);

  localparam int unsigned HW    = $clog2(HANDLES);
  localparam int unsigned WORDS = (SLOTS + rsba_pkg::WordBits - 1) / rsba_pkg::WordBits;
  localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned PW    = WW + 5;
  localparam int unsigned ClrN  = (HANDLES > WORDS) ? HANDLES : WORDS;
  localparam int unsigned CW    = $clog2(ClrN);
  localparam int unsigned LW    = ($clog2(SLOTS + 1) > rsba_pkg::CfgW) ?
                                  $clog2(SLOTS + 1) : rsba_pkg::CfgW;
  localparam int unsigned CMPW  = (PW > LW) ? PW : LW;
  localparam int unsigned HXW   = ((HW > rsba_pkg::HandleW) ? HW : rsba_pkg::HandleW) + 1;
  localparam int unsigned SXW   = (SW > rsba_pkg::SlotW) ? SW : rsba_pkg::SlotW;
  localparam int unsigned PXW   = (PW > rsba_pkg::SlotW) ? PW : rsba_pkg::SlotW;
  localparam int unsigned TW    = rsba_pkg::CountW + SW;
  localparam logic [WW-1:0] LastWord = WW'(WORDS - 1);

  // captured item
  logic                           op_q;
  logic                           oor_q;
  logic [HW-1:0]                  hidx_q;
  logic [WW-1:0]                  word_q;
  logic [CW-1:0]                  clr_q;
  logic [SW-1:0]                  fslot_q;
  logic [rsba_pkg::SlotW-1:0]     res_slot_q;
  logic [rsba_pkg::StatusW-1:0]   res_status_q;

  logic [HXW-1:0]                 hext;
  logic                           in_range;

  // handle table
  logic                           tbl_we;
  logic [HW-1:0]                  tbl_waddr;
  logic [TW-1:0]                  tbl_wdata;
  logic [TW-1:0]                  tbl_rdata;
  logic [rsba_pkg::CountW-1:0]    cnt;
  logic [SW-1:0]                  tslot;
  logic [rsba_pkg::SlotW-1:0]     tslot_out;
  logic                           cnt_zero;
  logic                           cnt_one;
  logic                           cnt_max;
  logic                           tbl_upd;
  logic [rsba_pkg::CountW-1:0]    cnt_new;

  // bitmap
  logic                           bm_we;
  logic [WW-1:0]                  bm_waddr;
  logic [rsba_pkg::WordBits-1:0]  bm_wdata;
  logic                           bm_re;
  logic [WW-1:0]                  bm_raddr;
  logic [rsba_pkg::WordBits-1:0]  bm_rdata;
  logic [PW-1:0]                  tslot_pos;
  logic [PW-1:0]                  fslot_pos;

  // scan
  logic [4:0]                     zbit;
  logic [PW-1:0]                  pos;
  logic [rsba_pkg::SlotW-1:0]     pos_out;
  logic [LW-1:0]                  lim_raw;
  logic [LW-1:0]                  lim;
  logic                           notfull;
  logic                           found;
  logic                           scan_done;

  logic                           clr_tbl;
  logic                           clr_bm;
  logic                           clr_done;

  logic [rsba_pkg::SlotW-1:0]     lk_slot;
  logic [rsba_pkg::StatusW-1:0]   lk_status;

  assign hext     = HXW'(handle_i);
  assign in_range = hext < HXW'(HANDLES);

  assign cnt       = tbl_rdata[TW-1:SW];
  assign tslot     = tbl_rdata[SW-1:0];
  assign tslot_out = SXW'(tslot);
  assign cnt_zero  = (cnt == '0);
  assign cnt_one   = (cnt == rsba_pkg::CountW'(1));
  assign cnt_max   = (cnt == rsba_pkg::CountMax);
  assign tbl_upd   = !oor_q && !cnt_zero && ((op_q == rsba_pkg::OpRemove) || !cnt_max);
  assign cnt_new   = (op_q == rsba_pkg::OpRemove) ? cnt - rsba_pkg::CountW'(1)
                                                  : cnt + rsba_pkg::CountW'(1);

  assign tslot_pos = PW'(tslot);
  assign fslot_pos = PW'(fslot_q);

  assign zbit    = rsba_pkg::first_zero(bm_rdata);
  assign pos     = {word_q, zbit};
  assign pos_out = PXW'(pos);
  assign lim_raw = LW'(usable_slots_i);
  assign lim     = (lim_raw > LW'(SLOTS)) ? LW'(SLOTS) : lim_raw;
  assign notfull = (bm_rdata != '1);
  assign found   = notfull && (CMPW'(pos) < CMPW'(lim));
  assign scan_done = notfull || (word_q == LastWord);

  assign clr_tbl  = (CW + 1)'(clr_q) < (CW + 1)'(HANDLES);
  assign clr_bm   = (CW + 1)'(clr_q) < (CW + 1)'(WORDS);
  assign clr_done = (clr_q == CW'(ClrN - 1));

  assign stat_o.clr_done  = clr_done;
  assign stat_o.need_scan = !oor_q && (op_q == rsba_pkg::OpAdd) && cnt_zero;
  assign stat_o.need_free = !oor_q && (op_q == rsba_pkg::OpRemove) && cnt_one;
  assign stat_o.scan_done = scan_done;

  // result of a lookup that needs no scan
  always_comb begin
    lk_slot   = '0;
    lk_status = rsba_pkg::StUnregistered;
    priority if (oor_q) begin
      lk_status = (op_q == rsba_pkg::OpAdd) ? rsba_pkg::StFull : rsba_pkg::StUnregistered;
    end else if (op_q == rsba_pkg::OpAdd) begin
      lk_slot   = tslot_out;
      lk_status = cnt_max ? rsba_pkg::StSaturated : rsba_pkg::StShared;
    end else if (cnt_zero) begin
      lk_status = rsba_pkg::StUnregistered;
    end else begin
      lk_slot   = tslot_out;
      lk_status = cnt_one ? rsba_pkg::StFreed : rsba_pkg::StDropped;
    end
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = hidx_q;
    tbl_wdata = '0;
    priority if (cmd_i.clr_step) begin
      tbl_we    = clr_tbl;
      tbl_waddr = clr_q[HW-1:0];
    end else if (cmd_i.lookup) begin
      tbl_we    = tbl_upd;
      tbl_wdata = {cnt_new, tslot};
    end else if (cmd_i.scan) begin
      tbl_we    = found;
      tbl_wdata = {rsba_pkg::CountW'(1), pos[SW-1:0]};
    end else begin
      tbl_we    = 1'b0;
    end
  end

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = word_q;
    bm_wdata = '0;
    priority if (cmd_i.clr_step) begin
      bm_we    = clr_bm;
      bm_waddr = clr_q[WW-1:0];
    end else if (cmd_i.scan) begin
      bm_we    = found;
      bm_wdata = bm_rdata | (rsba_pkg::WordBits'(1) << zbit);
    end else if (cmd_i.free_wr) begin
      bm_we    = 1'b1;
      bm_waddr = fslot_pos[PW-1:5];
      bm_wdata = bm_rdata & ~(rsba_pkg::WordBits'(1) << fslot_q[4:0]);
    end else begin
      bm_we    = 1'b0;
    end
  end

  always_comb begin
    bm_re    = 1'b0;
    bm_raddr = '0;
    priority if (cmd_i.lookup && stat_o.need_scan) begin
      bm_re = 1'b1;
    end else if (cmd_i.lookup && stat_o.need_free) begin
      bm_re    = 1'b1;
      bm_raddr = tslot_pos[PW-1:5];
    end else if (cmd_i.scan) begin
      // prefetch the next word while this one is checked
      bm_re    = !scan_done;
      bm_raddr = word_q + WW'(1);
    end else begin
      bm_re = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step && !clr_done) begin
      clr_q <= clr_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= opcode_i;
      oor_q  <= !in_range;
      hidx_q <= hext[HW-1:0];
    end
    if (cmd_i.lookup) begin
      word_q       <= '0;
      fslot_q      <= tslot;
      res_slot_q   <= lk_slot;
      res_status_q <= lk_status;
    end
    if (cmd_i.scan) begin
      if (scan_done) begin
        res_slot_q   <= found ? pos_out : '0;
        res_status_q <= found ? rsba_pkg::StNew : rsba_pkg::StFull;
      end else begin
        word_q <= word_q + WW'(1);
      end
    end
  end

  rsba_ram #(
    .WIDTH (TW),
    .DEPTH (HANDLES)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (hext[HW-1:0]),
    .rdata_o (tbl_rdata)
  );

  rsba_ram #(
    .WIDTH (rsba_pkg::WordBits),
    .DEPTH (WORDS)
  ) u_bm (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  assign res_slot_o   = res_slot_q;
  assign res_status_o = res_status_q;

  a_scan_in_bitmap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> word_q <= LastWord)
    else $error("scan word index past the last bitmap word");

  a_no_table_write_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.lookup && oor_q) |-> !tbl_we)
    else $error("table written for a handle out of range");

endmodule
